### hw/rtl/multi_wave_oscillator_bank_macros.svh
// Assertion helpers shared by the oscillator bank modules.
// Both expect a clock named clk in scope; MWOB_ASSERT also expects a synchronous reset named rst.
`ifndef MULTI_WAVE_OSCILLATOR_BANK_MACROS_SVH
`define MULTI_WAVE_OSCILLATOR_BANK_MACROS_SVH

// Checked only outside reset.
`define MWOB_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Checked on every edge, reset included.
`define MWOB_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) (expr)) else $error(msg);

`endif

### hw/rtl/mwob_pkg.sv
package mwob_pkg;

  localparam int MAX_OSC_DEFAULT    = 4;
  localparam int SINE_DEPTH_DEFAULT = 256;
  localparam int NUM_REG_OSC        = 4;

  localparam int TIME_W   = 32;
  localparam int FREQ_W   = 24;
  localparam int SAMPLE_W = 18;
  localparam int WAVE_W   = 16;
  localparam int KIND_W   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [15:0] LFSR_SEED = 16'hACE1;

  localparam longint Q30 = 64'sd1073741824;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_OSC_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_A     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_KINDS = 3'd5;

  typedef enum logic [KIND_W-1:0] {
    WAVE_SINE     = 3'd0,
    WAVE_SQUARE   = 3'd1,
    WAVE_TRIANGLE = 3'd2,
    WAVE_SAW      = 3'd3,
    WAVE_NOISE    = 3'd4
  } wave_t;

  // program steps
  typedef logic [2:0] step_t;
  localparam step_t STEP_IDLE  = 3'd0;
  localparam step_t STEP_MUL   = 3'd1;
  localparam step_t STEP_SHAPE = 3'd2;
  localparam step_t STEP_ROM   = 3'd3;
  localparam step_t STEP_ACC   = 3'd4;
  localparam step_t STEP_OUT   = 3'd5;

  typedef enum logic [1:0] {
    WAIT_NONE = 2'd0,
    WAIT_IN   = 2'd1,
    WAIT_OUT  = 2'd2
  } wait_t;

  typedef enum logic [1:0] {
    JMP_NEXT     = 2'd0,
    JMP_ALWAYS   = 2'd1,
    JMP_IF_EMPTY = 2'd2,
    JMP_IF_MORE  = 2'd3
  } jump_t;

  typedef struct packed {
    wait_t wait_on;
    logic  ld_time;
    logic  ld_phase;
    logic  ld_shape;
    logic  rd_rom;
    logic  acc_en;
    logic  ld_out;
    jump_t jump;
    step_t target;
  } ucode_t;

  typedef struct packed {
    ucode_t word;
    logic   go;
  } issue_t;

  typedef struct packed {
    logic empty;
    logic more;
  } dp_flags_t;

  function automatic ucode_t ucode_word(step_t pc);
    ucode_t w;
    w = '0;
    w.wait_on = WAIT_NONE;
    w.jump    = JMP_NEXT;
    w.target  = STEP_IDLE;
    unique case (pc)
      STEP_IDLE: begin
        w.wait_on = WAIT_IN;
        w.ld_time = 1'b1;
        w.jump    = JMP_IF_EMPTY;
        w.target  = STEP_OUT;
      end
      STEP_MUL:   w.ld_phase = 1'b1;
      STEP_SHAPE: w.ld_shape = 1'b1;
      STEP_ROM:   w.rd_rom   = 1'b1;
      STEP_ACC: begin
        w.acc_en = 1'b1;
        w.jump   = JMP_IF_MORE;
        w.target = STEP_MUL;
      end
      STEP_OUT: begin
        w.wait_on = WAIT_OUT;
        w.ld_out  = 1'b1;
        w.jump    = JMP_ALWAYS;
        w.target  = STEP_IDLE;
      end
      default: begin
        w.jump   = JMP_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  // Quarter-wave sine entry in unsigned Q0.15 for a position x in Q30 over [0,1].
  function automatic logic [14:0] sine_entry(longint x);
    longint y;
    longint acc;
    longint s;
    longint r;
    y   = (x * x) / Q30;
    acc = -64'sd3864;
    acc = 64'sd172273 + (acc * y) / Q30;
    acc = -64'sd5026994 + (acc * y) / Q30;
    acc = 64'sd85569306 + (acc * y) / Q30;
    acc = -64'sd693598668 + (acc * y) / Q30;
    acc = 64'sd1686629713 + (acc * y) / Q30;
    s   = (acc * x) / Q30;
    if (s < 0) s = 0;
    if (s > Q30) s = Q30;
    r = (s * 64'sd32767 + 64'sd536870912) >>> 30;
    if (r > 64'sd32767) r = 64'sd32767;
    return r[14:0];
  endfunction

endpackage

### hw/rtl/mwob_sine_rom.sv
module mwob_sine_rom #(
  parameter int SINE_TABLE_DEPTH = mwob_pkg::SINE_DEPTH_DEFAULT,
  localparam int AW = $clog2(SINE_TABLE_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] addr,
  output logic [14:0]   data
);

  logic [14:0] rom [SINE_TABLE_DEPTH + 1];

  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_entry
    localparam longint XPos = (longint'(g) * mwob_pkg::Q30) / SINE_TABLE_DEPTH;
    localparam logic [14:0] Entry = mwob_pkg::sine_entry(XPos);
    assign rom[g] = Entry;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      data <= rom[addr];
    end
  end

endmodule

### hw/rtl/mwob_sequencer.sv
module mwob_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                out_free,
  input  mwob_pkg::dp_flags_t flags,
  output mwob_pkg::issue_t    issue
);

  mwob_pkg::step_t  pc;
  mwob_pkg::step_t  pc_next;
  mwob_pkg::ucode_t word;
  logic             go;

  assign word = mwob_pkg::ucode_word(pc);

  // hold on a step that waits for an input word or a free output register
  always_comb begin
    unique case (word.wait_on)
      mwob_pkg::WAIT_IN:  go = in_valid;
      mwob_pkg::WAIT_OUT: go = out_free;
      default:            go = 1'b1;
    endcase
  end

  always_comb begin
    pc_next = pc;
    if (go) begin
      unique case (word.jump)
        mwob_pkg::JMP_ALWAYS:   pc_next = word.target;
        mwob_pkg::JMP_IF_EMPTY: pc_next = flags.empty ? word.target : pc + 3'd1;
        mwob_pkg::JMP_IF_MORE:  pc_next = flags.more ? word.target : pc + 3'd1;
        default:                pc_next = pc + 3'd1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= mwob_pkg::STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  assign issue.word = word;
  assign issue.go   = go;

endmodule

### hw/rtl/mwob_datapath.sv
`include "multi_wave_oscillator_bank_macros.svh"

module mwob_datapath #(
  parameter int NUM_OSC          = mwob_pkg::NUM_REG_OSC,
  parameter int SINE_TABLE_DEPTH = mwob_pkg::SINE_DEPTH_DEFAULT,
  localparam int KW = (NUM_OSC > 1) ? $clog2(NUM_OSC) : 1
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  mwob_pkg::issue_t                        issue,
  input  logic [mwob_pkg::TIME_W-1:0]             note_time,
  input  logic [mwob_pkg::FREQ_W-1:0]             freq [NUM_OSC],
  input  logic [mwob_pkg::KIND_W*NUM_OSC-1:0]     wave_kinds,
  input  logic [2:0]                              osc_count,
  output mwob_pkg::dp_flags_t                     flags,
  output logic signed [mwob_pkg::SAMPLE_W-1:0]    sum
);

  localparam int DW = $clog2(SINE_TABLE_DEPTH + 1);

  logic [mwob_pkg::TIME_W-1:0]          note_t;
  logic [KW-1:0]                        osc_idx;
  logic [2:0]                           eff_count;
  logic [31:0]                          phase;
  logic [mwob_pkg::KIND_W-1:0]          kind_q;
  logic signed [mwob_pkg::WAVE_W-1:0]   wave_q;
  logic signed [mwob_pkg::WAVE_W-1:0]   wave_next;
  logic                                 use_sine;
  logic [1:0]                           quad_q;
  logic [DW-1:0]                        idx_q;
  logic [29+DW:0]                       idx_prod;
  logic [DW-1:0]                        rom_addr;
  logic [14:0]                          rom_data;
  logic [15:0]                          lfsr;
  logic [15:0]                          lfsr_step;
  logic [16:0]                          tri_v;
  logic signed [17:0]                   tri_fall;
  logic signed [mwob_pkg::SAMPLE_W-1:0] sine_val;
  logic signed [mwob_pkg::SAMPLE_W-1:0] osc_val;

  logic do_time;
  logic do_phase;
  logic do_shape;
  logic do_acc;

  assign do_time  = issue.go && issue.word.ld_time;
  assign do_phase = issue.go && issue.word.ld_phase;
  assign do_shape = issue.go && issue.word.ld_shape;
  assign do_acc   = issue.go && issue.word.acc_en;

  assign eff_count   = (osc_count > 3'(NUM_OSC)) ? 3'(NUM_OSC) : osc_count;
  assign flags.empty = (eff_count == 3'd0);
  assign flags.more  = ((3'(osc_idx) + 3'd1) < eff_count);

  always_ff @(posedge clk) begin
    if (do_time) begin
      note_t <= note_time;
    end
    if (do_phase) begin
      phase  <= 32'(freq[osc_idx]) * note_t;
      kind_q <= wave_kinds[mwob_pkg::KIND_W*osc_idx +: mwob_pkg::KIND_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      osc_idx <= '0;
    end else if (do_time) begin
      osc_idx <= '0;
    end else if (do_acc && flags.more) begin
      osc_idx <= osc_idx + KW'(1);
    end
  end

  // Fibonacci LFSR, taps 16,14,13,11
  assign lfsr_step = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= mwob_pkg::LFSR_SEED;
    end else if (do_shape && kind_q == mwob_pkg::WAVE_NOISE) begin
      lfsr <= lfsr_step;
    end
  end

  assign tri_v    = phase[31:15];
  assign tri_fall = 18'sd65536 - $signed({1'b0, tri_v});
  assign idx_prod = {DW'(0), phase[29:0]} * (30 + DW)'(SINE_TABLE_DEPTH);

  always_comb begin
    wave_next = '0;
    unique case (mwob_pkg::wave_t'(kind_q))
      mwob_pkg::WAVE_SINE: wave_next = '0;
      mwob_pkg::WAVE_SQUARE: begin
        wave_next = (phase != 32'd0 && !phase[31]) ? 16'sh7FFF : 16'sh8000;
      end
      mwob_pkg::WAVE_TRIANGLE: begin
        if (!tri_v[16] && !tri_v[15]) begin
          wave_next = $signed({1'b0, tri_v[14:0]});
        end else if (tri_v < 17'd98304) begin
          // falling segment starts at +1.0; clamp it
          wave_next = (tri_fall > 18'sd32767) ? 16'sh7FFF : tri_fall[15:0];
        end else begin
          wave_next = $signed(tri_v[15:0]);
        end
      end
      mwob_pkg::WAVE_SAW:   wave_next = $signed({~phase[31], phase[30:16]});
      mwob_pkg::WAVE_NOISE: wave_next = $signed({~lfsr_step[15], lfsr_step[14:0]});
      default:              wave_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_shape) begin
      wave_q   <= wave_next;
      use_sine <= (kind_q == mwob_pkg::WAVE_SINE);
      quad_q   <= phase[31:30];
      idx_q    <= idx_prod[29+DW:30];
    end
  end

  // odd quadrants run the table backward
  assign rom_addr = quad_q[0] ? (DW'(SINE_TABLE_DEPTH) - idx_q) : idx_q;

  mwob_sine_rom #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_sine_rom (
    .clk   (clk),
    .rd_en (issue.go && issue.word.rd_rom),
    .addr  (rom_addr),
    .data  (rom_data)
  );

  assign sine_val = quad_q[1] ? -$signed({3'b000, rom_data}) : $signed({3'b000, rom_data});
  assign osc_val  = use_sine ? sine_val : mwob_pkg::SAMPLE_W'(wave_q);

  always_ff @(posedge clk) begin
    if (do_time) begin
      sum <= '0;
    end else if (do_acc) begin
      sum <= sum + osc_val;
    end
  end

  `MWOB_ASSERT(a_osc_idx_range, int'(osc_idx) < NUM_OSC, "oscillator index out of range")
  `MWOB_ASSERT(a_lfsr_nonzero, lfsr != 16'd0, "noise LFSR locked at zero")
  `MWOB_ASSERT(a_sum_cleared, do_time |=> (sum == '0), "sum not cleared on new word")

endmodule

### hw/rtl/multi_wave_oscillator_bank.sv
// Additive oscillator bank: one note time in, one mixed sample out.
// Input channel in_valid/in_ready carries note_time (Q8.24 seconds); output
// channel out_valid/out_ready carries mix_sample (signed Q3.15).
// Configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data writes
// osc_count (0), freq_a..freq_d (1..4, Q16.8 Hz) and wave_kinds (5); other
// indexes are dropped. cfg_ready is always high; write only while idle.
// A short microprogram steps one shared multiply / shaping / sine table path
// through the oscillators in use, taking each through phase multiply, shape and
// table index multiply, registered table read and accumulate.
// An item is finished before the next input word is accepted: the next word
// can be taken in the cycle after the result is loaded into the output register.
// A result waiting on out_ready does not block acceptance of the next word;
// that next item finishes its work and holds in the final step until the
// output register frees.
// Reset clears the configuration registers to zero, seeds the noise LFSR
// with 0xACE1 and leaves the output empty.
`include "multi_wave_oscillator_bank_macros.svh"

module multi_wave_oscillator_bank #(
  parameter int MAX_OSC          = mwob_pkg::MAX_OSC_DEFAULT,
  parameter int SINE_TABLE_DEPTH = mwob_pkg::SINE_DEPTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mwob_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mwob_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [mwob_pkg::TIME_W-1:0]           note_time,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [mwob_pkg::SAMPLE_W-1:0]  mix_sample
);

  localparam int NUM_OSC = (MAX_OSC < mwob_pkg::NUM_REG_OSC) ? MAX_OSC
                                                             : mwob_pkg::NUM_REG_OSC;

  logic [2:0]                               osc_count;
  logic [mwob_pkg::FREQ_W-1:0]              freq [NUM_OSC];
  logic [mwob_pkg::KIND_W*NUM_OSC-1:0]      wave_kinds;
  mwob_pkg::issue_t                         issue;
  mwob_pkg::dp_flags_t                      flags;
  logic signed [mwob_pkg::SAMPLE_W-1:0]     sum;
  logic                                     out_free;
  logic                                     cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      osc_count  <= '0;
      wave_kinds <= '0;
      for (int j = 0; j < NUM_OSC; j++) begin
        freq[j] <= '0;
      end
    end else if (cfg_write) begin
      if (cfg_index == mwob_pkg::REG_OSC_COUNT) begin
        osc_count <= cfg_data[2:0];
      end
      if (cfg_index == mwob_pkg::REG_WAVE_KINDS) begin
        wave_kinds <= cfg_data[mwob_pkg::KIND_W*NUM_OSC-1:0];
      end
      // frequency slots past the bank size are dropped
      for (int j = 0; j < NUM_OSC; j++) begin
        if (cfg_index == mwob_pkg::REG_FREQ_A + mwob_pkg::CFG_IDX_W'(j)) begin
          freq[j] <= cfg_data;
        end
      end
    end
  end

  assign out_free = !out_valid || out_ready;
  assign in_ready = (issue.word.wait_on == mwob_pkg::WAIT_IN);

  mwob_sequencer u_sequencer (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (out_free),
    .flags    (flags),
    .issue    (issue)
  );

  mwob_datapath #(
    .NUM_OSC          (NUM_OSC),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .issue      (issue),
    .note_time  (note_time),
    .freq       (freq),
    .wave_kinds (wave_kinds),
    .osc_count  (osc_count),
    .flags      (flags),
    .sum        (sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (issue.go && issue.word.ld_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue.go && issue.word.ld_out) begin
      mix_sample <= sum;
    end
  end

  `MWOB_ASSERT(a_one_item, (in_valid && in_ready) |=> !in_ready, "second word taken mid-item")
  `MWOB_ASSERT(a_load_free, (issue.go && issue.word.ld_out) |-> out_free, "result overwritten")
  `MWOB_ASSERT(a_rise_load, $rose(out_valid) |-> $past(issue.go && issue.word.ld_out), "stray result")

endmodule

### tb/mwob_mix_checker.sv
module mwob_mix_checker
  import mwob_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [TIME_W-1:0]          note_time,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic signed [SAMPLE_W-1:0] mix_sample,
  output int                         samples_owed,
  output int                         mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = SINE_DEPTH_DEFAULT;
  localparam int BANK_SIZE   = (MAX_OSC_DEFAULT < NUM_REG_OSC) ? MAX_OSC_DEFAULT : NUM_REG_OSC;
  localparam longint UNIT_Q30 = longint'(1) << 30;

  int                            quarter_wave [0:TABLE_DEPTH];
  logic [2:0]                    osc_in_use;
  logic [FREQ_W-1:0]             osc_freq [NUM_REG_OSC];
  logic [NUM_REG_OSC*KIND_W-1:0] osc_kinds;
  logic [15:0]                   noise_reg;
  logic signed [SAMPLE_W-1:0]    expected_mix [$];
  int                            error_tally = 0;

  // sin(pi/2 * x), x in Q30 over [0,1], odd polynomial evaluated by Horner steps
  function automatic longint poly_quarter_sine(longint x);
    longint coef [0:5];
    longint sq;
    longint acc;
    coef[0] = -3864;
    coef[1] = 172273;
    coef[2] = -5026994;
    coef[3] = 85569306;
    coef[4] = -693598668;
    coef[5] = 1686629713;
    sq  = (x * x) / UNIT_Q30;
    acc = coef[0];
    for (int i = 1; i < 6; i++) acc = coef[i] + (acc * sq) / UNIT_Q30;
    return (acc * x) / UNIT_Q30;
  endfunction

  initial begin : build_quarter_wave
    longint s;
    longint r;
    for (int i = 0; i <= TABLE_DEPTH; i++) begin
      s = poly_quarter_sine((longint'(i) * UNIT_Q30) / TABLE_DEPTH);
      if (s < 0) s = 0;
      if (s > UNIT_Q30) s = UNIT_Q30;
      r = (s * 32767 + (longint'(1) << 29)) >>> 30;
      if (r > 32767) r = 32767;
      quarter_wave[i] = int'(r);
    end
  end

  function automatic int sine_value(logic [31:0] phase);
    int idx;
    int v;
    idx = int'((longint'(phase[29:0]) * TABLE_DEPTH) >>> 30);
    // odd quadrants run the table backwards, upper half is negated
    if (phase[30]) idx = TABLE_DEPTH - idx;
    v = quarter_wave[idx];
    return phase[31] ? -v : v;
  endfunction

  function automatic int triangle_value(logic [31:0] phase);
    int v;
    int r;
    v = int'(phase[31:15]);
    if (v < 32768) r = v;
    else if (v < 98304) r = 65536 - v;
    else r = v - 131072;
    return (r > 32767) ? 32767 : r;
  endfunction

  // step the noise register first, then read it
  function automatic int next_noise();
    logic fb;
    fb = noise_reg[0] ^ noise_reg[2] ^ noise_reg[3] ^ noise_reg[5];
    noise_reg = {fb, noise_reg[15:1]};
    return int'(noise_reg) - 32768;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] predict_mix(logic [TIME_W-1:0] t);
    int          sum;
    int          used;
    int          v;
    logic [55:0] prod;
    logic [31:0] phase;
    wave_t       kind;
    sum  = 0;
    used = (osc_in_use > BANK_SIZE) ? BANK_SIZE : int'(osc_in_use);
    for (int k = 0; k < used; k++) begin
      prod  = osc_freq[k] * t;
      phase = prod[31:0];
      kind  = wave_t'(osc_kinds[k*KIND_W +: KIND_W]);
      case (kind)
        WAVE_SINE:     v = sine_value(phase);
        WAVE_SQUARE:   v = (phase != 0 && !phase[31]) ? 32767 : -32768;
        WAVE_TRIANGLE: v = triangle_value(phase);
        WAVE_SAW:      v = int'(phase[31:16]) - 32768;
        WAVE_NOISE:    v = next_noise();
        default:       v = 0;
      endcase
      sum += v;
    end
    return sum[SAMPLE_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic signed [SAMPLE_W-1:0] got,
                                 input logic signed [SAMPLE_W-1:0] want);
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    error_tally++;
  endtask

  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] want;
    if (rst) begin
      osc_in_use = '0;
      for (int k = 0; k < NUM_REG_OSC; k++) osc_freq[k] = '0;
      osc_kinds = '0;
      noise_reg = LFSR_SEED;
      expected_mix.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_OSC_COUNT) osc_in_use = cfg_data[2:0];
        else if (cfg_index == REG_WAVE_KINDS) osc_kinds = cfg_data[NUM_REG_OSC*KIND_W-1:0];
        else if (cfg_index >= REG_FREQ_A && cfg_index < REG_FREQ_A + NUM_REG_OSC)
          osc_freq[cfg_index - REG_FREQ_A] = cfg_data[FREQ_W-1:0];
        // other indexes: drop
      end
      if (in_valid && in_ready) expected_mix.push_back(predict_mix(note_time));
      if (out_valid && out_ready) begin
        if (expected_mix.size() == 0) begin
          report_mismatch("mix_sample with no word outstanding", mix_sample, '0);
        end else begin
          want = expected_mix.pop_front();
          if (mix_sample !== want) report_mismatch("mix_sample", mix_sample, want);
        end
      end
    end
    samples_owed <= expected_mix.size();
    mismatches   <= error_tally;
  end

endmodule

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mwob_pkg::*;

  localparam int RUN_LIMIT       = 300000;
  localparam int HOLD_CYCLES     = 400;
  localparam int RANDOM_PHASES   = 11;
  localparam int ITEMS_PER_PHASE = 85;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI      = 3'd7;
  localparam logic [KIND_W-1:0]    KIND_UNUSED_FIRST = 3'd5;
  localparam logic [KIND_W-1:0]    KIND_UNUSED_LAST  = 3'd7;
  localparam logic [FREQ_W-1:0]    ONE_HERTZ         = 24'd256;
  localparam logic [FREQ_W-1:0]    A4_HERTZ          = 24'd112640;
  localparam logic [FREQ_W-1:0]    FREQ_MAX          = {FREQ_W{1'b1}};
  localparam logic [TIME_W-1:0]    QUARTER_SEC       = 32'h0040_0000;
  localparam logic [TIME_W-1:0]    ONE_SEC           = 32'h0100_0000;
  localparam logic [TIME_W-1:0]    TIME_MAX          = {TIME_W{1'b1}};

  logic                       clk        = 1'b0;
  logic                       rst        = 1'b1;
  logic                       cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index  = '0;
  logic [CFG_DATA_W-1:0]      cfg_data   = '0;
  logic                       in_valid   = 1'b0;
  logic [TIME_W-1:0]          note_time  = '0;
  logic                       out_ready  = 1'b0;
  logic                       cfg_ready;
  logic                       in_ready;
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] mix_sample;
  int                         samples_owed;
  int                         mismatches;
  int                         cycle_count = 0;
  int                         burst_left  = 0;
  bit                         hold_off_req = 1'b0;

  multi_wave_oscillator_bank dut (.*);

  mwob_mix_checker mix_monitor (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [NUM_REG_OSC*KIND_W-1:0] pack_kinds(
    input logic [KIND_W-1:0] k0, input logic [KIND_W-1:0] k1,
    input logic [KIND_W-1:0] k2, input logic [KIND_W-1:0] k3);
    return {k3, k2, k1, k0};
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind();
    if ($urandom_range(0, 7) == 0) return KIND_W'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
    return KIND_W'($urandom_range(WAVE_SINE, WAVE_NOISE));
  endfunction

  function automatic logic [FREQ_W-1:0] pick_freq();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return FREQ_MAX;
      2, 3:    return FREQ_W'($urandom_range(256, 20000 * 256));
      4:       return FREQ_W'(1) << $urandom_range(0, FREQ_W - 1);
      default: return FREQ_W'($urandom);
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? TIME_MAX : '0;
      1:       return $urandom_range(0, ONE_SEC - 1);
      2:       return $urandom << $urandom_range(12, 31);
      default: return $urandom;
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // only called with the bank idle
  task automatic program_bank(input logic [2:0] count,
                              input logic [FREQ_W-1:0] fa, input logic [FREQ_W-1:0] fb,
                              input logic [FREQ_W-1:0] fc, input logic [FREQ_W-1:0] fd,
                              input logic [NUM_REG_OSC*KIND_W-1:0] kinds);
    logic [FREQ_W-1:0]     freqs [NUM_REG_OSC];
    logic [CFG_DATA_W-1:0] pad;
    freqs = '{fa, fb, fc, fd};
    // junk in the unused upper bits must be ignored
    pad = $urandom;
    write_reg(REG_OSC_COUNT, {pad[CFG_DATA_W-1:3], count});
    for (int k = 0; k < NUM_REG_OSC; k++) write_reg(CFG_IDX_W'(REG_FREQ_A + k), freqs[k]);
    pad = $urandom;
    write_reg(REG_WAVE_KINDS, {pad[CFG_DATA_W-1:NUM_REG_OSC*KIND_W], kinds});
    if ($urandom_range(0, 1) == 1) begin
      write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
      write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic offer(input logic [TIME_W-1:0] t);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    note_time <= t;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold the sender until every word sent has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (samples_owed != 0);
  endtask

  initial begin : sink
    int run_left;
    bit run_val;
    run_left = 0;
    run_val  = 1'b1;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (run_left == 0) begin
          if ($urandom_range(0, 7) == 0) begin
            run_val  = 1'b1;
            run_left = $urandom_range(30, 80);
          end else begin
            run_val  = !run_val;
            run_left = run_val ? $urandom_range(1, 10) : $urandom_range(1, 6);
          end
        end
        run_left--;
        out_ready <= run_val;
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** multi_wave_oscillator_bank: FAILED **");
    $finish;
  end

  initial begin : stimulus
    logic [FREQ_W-1:0] f0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // sine, square, triangle and saw, with quadrant and half-turn edges
    program_bank(3'd4, ONE_HERTZ, ONE_HERTZ, FREQ_MAX, A4_HERTZ,
                 pack_kinds(WAVE_SINE, WAVE_SQUARE, WAVE_TRIANGLE, WAVE_SAW));
    offer('0);
    offer(TIME_MAX);
    offer(32'd1);
    offer(QUARTER_SEC);
    offer(2 * QUARTER_SEC);
    offer(3 * QUARTER_SEC);
    offer(ONE_SEC);
    offer(32'h8000_0000);
    drain();

    // count above the bank size, noise next to unknown codes
    program_bank(3'd7, pick_freq(), pick_freq(), pick_freq(), pick_freq(),
                 pack_kinds(WAVE_NOISE, KIND_UNUSED_FIRST, WAVE_NOISE, KIND_UNUSED_LAST));
    repeat (4) offer($urandom);
    drain();

    program_bank(3'd0, FREQ_MAX, FREQ_MAX, FREQ_MAX, FREQ_MAX,
                 pack_kinds(WAVE_SAW, WAVE_SAW, WAVE_SAW, WAVE_SAW));
    repeat (2) offer($urandom);
    drain();

    // zero frequency pins every phase at zero
    program_bank(3'd4, '0, '0, '0, '0,
                 pack_kinds(WAVE_TRIANGLE, WAVE_SAW, WAVE_SINE, WAVE_SQUARE));
    offer('0);
    offer(TIME_MAX);
    offer($urandom);
    drain();

    // triangle peak clips, trough does not
    program_bank(3'd1, ONE_HERTZ, '0, '0, '0,
                 pack_kinds(WAVE_TRIANGLE, WAVE_SINE, WAVE_SINE, WAVE_SINE));
    offer(QUARTER_SEC);
    offer(QUARTER_SEC - 1);
    offer(2 * QUARTER_SEC);
    offer(3 * QUARTER_SEC);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0) begin
        program_bank(3'd4, FREQ_MAX, FREQ_MAX, FREQ_MAX, FREQ_MAX,
                     pack_kinds(pick_kind(), pick_kind(), pick_kind(), pick_kind()));
      end else if (ph == 1) begin
        program_bank(3'd4, pick_freq(), pick_freq(), pick_freq(), pick_freq(),
                     pack_kinds(WAVE_NOISE, WAVE_NOISE, WAVE_NOISE, WAVE_NOISE));
      end else begin
        f0 = pick_freq();
        program_bank($urandom_range(0, 1) ? 3'd4 : 3'($urandom_range(0, 7)),
                     f0, pick_freq(), pick_freq(), pick_freq(),
                     pack_kinds(pick_kind(), pick_kind(), pick_kind(), pick_kind()));
      end
      // sink stops taking samples while words keep coming
      if (ph == 3) hold_off_req = 1'b1;
      repeat (ITEMS_PER_PHASE) offer(pick_time());
      drain();
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("** multi_wave_oscillator_bank: PASSED **");
    end else begin
      $display("** multi_wave_oscillator_bank: FAILED **");
    end
    $finish;
  end

endmodule
